@@ rtl/core/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// chm_pkg
// shared status and opcode codes and field widths for the chained hash map
// ----------------------------------------------------------------------------
`default_nettype none
package chm_pkg;
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_DUP     = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int CFG_W   = 9;
   localparam int COUNT_W = 11;
endpackage
`default_nettype wire

@@ rtl/core/chained_hash_map.sv @@
// after reset the bucket heads and the free list are filled together, one entry per cycle;
// req_tready stays low until both finish.
// each request runs the modulo, reads the head, reads each chain node visited, checks,
// commits an insert or a remove, loads the result and then returns to idle.
// the result waits in an output register; a new request is taken while it waits.
// reset is synchronous and active high.
`default_nettype none
module chained_hash_map #(
   parameter int MAX_BUCKETS = 256,
   parameter int POOL_NODES  = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [8:0]  csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // opcode[1:0], key[33:2], value[65:34], zero fill to 72
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], found_value[33:2], entries[44:34], zero fill to 48
   output logic [47:0]      rsp_tdata
);
   localparam int BA = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NA = $clog2(POOL_NODES);
   localparam int BW = $clog2(MAX_BUCKETS + 1);
   localparam int FW = $clog2(POOL_NODES + 1);
   localparam int HW = NA + 1;
   localparam int HD = 1 << BA;
   localparam int INIT_N = (POOL_NODES > HD) ? POOL_NODES : HD;
   localparam int IW = $clog2(INIT_N) + 1;
   localparam int CFG_BITS = chm_pkg::CFG_W;

   localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_MOD = 4'd2, S_HEAD = 4'd3,
      S_HEADW = 4'd4, S_NODE = 4'd5, S_NODEW = 4'd6, S_CHECK = 4'd7, S_FREE = 4'd8,
      S_FREEW = 4'd9, S_INS = 4'd10, S_LINK = 4'd11, S_FREEPUSH = 4'd12, S_DONE = 4'd13;

   logic [3:0]          state_ff, state_in;
   logic [CFG_BITS-1:0] bcnt_ff;
   logic [1:0]          op_ff;
   logic [31:0]         key_ff, val_ff;
   logic [BA-1:0]       bkt_ff;
   logic [NA-1:0]       cur_ff, prev_ff, new_ff;
   logic                prev_ok_ff;
   logic [FW-1:0]       steps_ff;
   logic [FW-1:0]       free_ff;
   logic [chm_pkg::COUNT_W-1:0] ent_ff;
   logic [IW-1:0]       init_ff;
   logic [HW-1:0]       link_ff;
   logic [1:0]          st_ff;
   logic [31:0]         fv_ff;
   logic                ov_ff;
   logic [47:0]         od_ff;

   logic [BW-1:0]       div_use;
   logic                mod_done;
   logic [BW-1:0]       mod_rem;

   // bucket head ram: {valid, index}
   logic                h_we;
   logic [BA-1:0]       h_addr;
   logic [HW-1:0]       h_wd, h_rd;
   // node key/value/link rams, free list ram
   logic                k_we, v_we, l_we, f_we;
   logic [NA-1:0]       n_addr, f_addr;
   logic [31:0]         k_rd, v_rd;
   logic [HW-1:0]       l_wd, l_rd;
   logic [NA-1:0]       f_wd, f_rd;
   logic                req_fire;

   always_comb begin
      if (bcnt_ff == '0) begin
         div_use = BW'(1);
      end else if (32'(bcnt_ff) > MAX_BUCKETS) begin
         div_use = BW'(MAX_BUCKETS);
      end else begin
         div_use = BW'(bcnt_ff);
      end
   end

   assign req_fire = req_tvalid && req_tready;

   chm_mod #(.BW(BW)) u_mod (
      .clock(clock), .reset(reset), .start(req_fire),
      .dividend(req_tdata[33:2]), .divisor(div_use),
      .done(mod_done), .remainder(mod_rem)
   );

   chm_ram #(.WIDTH(HW), .DEPTH(1 << BA)) u_heads (
      .clock(clock), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
   chm_ram #(.WIDTH(32), .DEPTH(1 << NA)) u_keys (
      .clock(clock), .we(k_we), .addr(n_addr), .wdata(key_ff), .rdata(k_rd));
   chm_ram #(.WIDTH(32), .DEPTH(1 << NA)) u_vals (
      .clock(clock), .we(v_we), .addr(n_addr), .wdata(val_ff), .rdata(v_rd));
   chm_ram #(.WIDTH(HW), .DEPTH(1 << NA)) u_links (
      .clock(clock), .we(l_we), .addr(n_addr), .wdata(l_wd), .rdata(l_rd));
   chm_ram #(.WIDTH(NA), .DEPTH(1 << NA)) u_free (
      .clock(clock), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

   logic key_hit;
   assign key_hit = (k_rd == key_ff);

   always_comb begin
      state_in = state_ff;
      h_we = 1'b0; h_addr = bkt_ff; h_wd = '0;
      k_we = 1'b0; v_we = 1'b0; l_we = 1'b0; l_wd = '0;
      n_addr = cur_ff;
      f_we = 1'b0; f_addr = NA'(free_ff - 1'b1); f_wd = cur_ff;
      unique case (state_ff)
         S_INIT: begin
            h_we = (init_ff < IW'(HD)) ? 1'b1 : 1'b0;
            h_addr = init_ff[BA-1:0];
            f_we = (init_ff < IW'(POOL_NODES)) ? 1'b1 : 1'b0;
            f_addr = init_ff[NA-1:0];
            f_wd = init_ff[NA-1:0];
            if (init_ff == IW'(INIT_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD:  state_in = S_HEADW;
         S_HEADW: begin
            if (op_ff == chm_pkg::OP_LOOKUP || op_ff == chm_pkg::OP_INSERT ||
                op_ff == chm_pkg::OP_REMOVE) begin
               state_in = h_rd[NA] ? S_NODE : S_CHECK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_NODE:  state_in = S_NODEW;
         S_NODEW: begin
            if (key_hit || !l_rd[NA] || steps_ff == FW'(POOL_NODES - 1)) begin
               state_in = S_CHECK;
            end else begin
               state_in = S_NODE;
            end
         end
         S_CHECK: begin
            state_in = S_DONE;
            if (op_ff == chm_pkg::OP_INSERT && !link_ff[NA] && free_ff != '0) begin
               state_in = S_FREE;
            end else if (op_ff == chm_pkg::OP_REMOVE && link_ff[NA]) begin
               n_addr = prev_ff;
               if (prev_ok_ff) begin
                  l_we = 1'b1;
                  l_wd = l_rd;
               end else begin
                  h_we = 1'b1;
                  h_wd = l_rd;
               end
               state_in = S_FREEPUSH;
            end
         end
         S_FREE:  state_in = S_FREEW;
         S_FREEW: begin
            n_addr = f_rd;
            k_we = 1'b1; v_we = 1'b1; l_we = 1'b1; l_wd = '0;
            state_in = S_LINK;
         end
         S_LINK: begin
            n_addr = prev_ff;
            if (prev_ok_ff) begin
               l_we = 1'b1;
               l_wd = {1'b1, new_ff};
            end else begin
               h_we = 1'b1;
               h_wd = {1'b1, new_ff};
            end
            state_in = S_DONE;
         end
         S_FREEPUSH: begin
            n_addr = cur_ff;
            l_we = 1'b1; l_wd = '0;
            f_addr = free_ff[NA-1:0];
            f_we = (free_ff < FW'(POOL_NODES));
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!ov_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff  <= '0;
         bcnt_ff  <= 9'd256;
         free_ff  <= FW'(POOL_NODES);
         ent_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_INIT) begin
            init_ff <= init_ff + 1'b1;
         end
         if (csr_valid && csr_ready) begin
            bcnt_ff <= csr_data;
         end
         if (state_ff == S_FREE) begin
            free_ff <= free_ff - 1'b1;
         end
         if (state_ff == S_LINK) begin
            ent_ff <= ent_ff + 1'b1;
         end
         if (state_ff == S_FREEPUSH) begin
            if (free_ff < FW'(POOL_NODES)) begin
               free_ff <= free_ff + 1'b1;
            end
            if (ent_ff != '0) begin
               ent_ff <= ent_ff - 1'b1;
            end
         end
         if (state_ff == S_DONE && (!ov_ff || rsp_tready)) begin
            ov_ff <= 1'b1;
         end else if (rsp_tready) begin
            ov_ff <= 1'b0;
         end
      end
      unique case (state_ff)
         S_IDLE: begin
            op_ff  <= req_tdata[1:0];
            key_ff <= req_tdata[33:2];
            val_ff <= req_tdata[65:34];
            prev_ok_ff <= 1'b0;
            prev_ff <= '0;
            steps_ff <= '0;
            link_ff <= '0;
            st_ff <= chm_pkg::ST_OK;
            fv_ff <= '0;
         end
         S_MOD: bkt_ff <= BA'(mod_rem);
         S_HEADW: begin
            cur_ff  <= h_rd[NA-1:0];
         end
         S_NODEW: begin
            if (key_hit) begin
               link_ff <= {1'b1, cur_ff};
               fv_ff   <= v_rd;
            end else begin
               prev_ok_ff <= 1'b1;
               prev_ff  <= cur_ff;
               cur_ff   <= l_rd[NA-1:0];
               steps_ff <= steps_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (op_ff == chm_pkg::OP_LOOKUP) begin
               st_ff <= link_ff[NA] ? chm_pkg::ST_OK : chm_pkg::ST_MISSING;
               if (!link_ff[NA]) fv_ff <= '0;
            end else begin
               fv_ff <= '0;
               if (op_ff == chm_pkg::OP_INSERT) begin
                  st_ff <= link_ff[NA] ? chm_pkg::ST_DUP :
                           (free_ff == '0) ? chm_pkg::ST_FULL : chm_pkg::ST_OK;
               end else begin
                  st_ff <= link_ff[NA] ? chm_pkg::ST_OK : chm_pkg::ST_MISSING;
               end
            end
         end
         S_FREEW: new_ff <= f_rd;
         default: begin
         end
      endcase
      if (state_ff == S_DONE && (!ov_ff || rsp_tready)) begin
         od_ff <= {3'b0, ent_ff, fv_ff, st_ff};
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
endmodule
`default_nettype wire

@@ rtl/core/chm_ram.sv @@
// ----------------------------------------------------------------------------
// chm_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

@@ rtl/core/chm_mod.sv @@
// ----------------------------------------------------------------------------
// chm_mod
// restoring divider giving key modulo bucket count, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module chm_mod #(
   parameter int BW = 9
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [chm_pkg::KEY_W-1:0]     dividend,
   input  wire logic [BW-1:0]                 divisor,
   output logic                               done,
   output logic [BW-1:0]                      remainder
);
   localparam int CW = $clog2(chm_pkg::KEY_W + 1);

   logic [chm_pkg::KEY_W-1:0] quo_ff, quo_in;
   logic [BW:0]               rem_ff, rem_in;
   logic [BW-1:0]             div_ff, div_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic [BW:0]               shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[BW-1:0], quo_ff[chm_pkg::KEY_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(chm_pkg::KEY_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[chm_pkg::KEY_W-2:0], 1'b0};
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = shifted - {1'b0, div_ff};
         end else begin
            rem_in = shifted;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = busy_ff && (cnt_ff == CW'(1));
   assign remainder = rem_in[BW-1:0];
endmodule
`default_nettype wire

@@ rtl/core/chm_checker.sv @@
// ----------------------------------------------------------------------------
// chm_checker
// port level checks for the chained hash map
// ----------------------------------------------------------------------------
`default_nettype none
module chm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:45] == 3'b0)
      else $error("pad bits set");
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != chm_pkg::ST_OK |-> rsp_tdata[33:2] == 32'd0)
      else $error("value on failure");
endmodule

bind chained_hash_map chm_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire

@@ verif/chained_hash_map_test.sv @@
// ----------------------------------------------------------------------------
// chained_hash_map_test
// drives lookup, insert, remove and no-op requests into the chained hash map under
// several bucket counts, predicts each response from a behavioural copy of the
// table, and compares status, value and entry count in arrival order
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_map_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBUCK = 256;
   localparam int NPOOL = 1024;

   typedef struct packed {
      logic [10:0] entries;
      logic [31:0] found;
      logic [1:0]  status;
   } rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [8:0]  csr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;

   chained_hash_map u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // behavioural table
   logic [8:0]  m_bucket_reg;
   logic [9:0]  m_head [NBUCK];
   bit          m_head_ok [NBUCK];
   logic [31:0] m_key [NPOOL];
   logic [31:0] m_val [NPOOL];
   logic [9:0]  m_link [NPOOL];
   bit          m_link_ok [NPOOL];
   logic [9:0]  m_free [NPOOL];
   int          m_free_n;
   int          m_total;

   rsp_type     pending_rsp [$];
   logic [31:0] live_keys [$];
   int          mismatches = 0;
   int          stall_hold = 0;
   int          stall_asked = 0;
   int          stall_seen = 0;
   bit          burst_mode = 1;

   function automatic rsp_type predict_request(logic [1:0] op, logic [31:0] key,
                                               logic [31:0] val);
      int nb, b, steps, node, prev;
      bit hit, has_prev, cur_ok;
      int cur;
      rsp_type r;
      nb = (m_bucket_reg == 0) ? 1 : (m_bucket_reg > NBUCK ? NBUCK : m_bucket_reg);
      b = key % nb;
      r = '0;
      if (op <= chm_pkg::OP_REMOVE) begin
         cur_ok = m_head_ok[b];
         cur = m_head[b];
         steps = 0; hit = 0; has_prev = 0; prev = 0; node = 0;
         while (cur_ok && steps < NPOOL && !hit) begin
            if (m_key[cur] == key) begin
               hit = 1; node = cur;
            end else begin
               has_prev = 1; prev = cur;
               cur_ok = m_link_ok[cur]; cur = m_link[cur];
               steps++;
            end
         end
         if (op == chm_pkg::OP_LOOKUP) begin
            if (hit) r.found = m_val[node];
            else r.status = chm_pkg::ST_MISSING;
         end else if (op == chm_pkg::OP_INSERT) begin
            if (hit) r.status = chm_pkg::ST_DUP;
            else if (m_free_n == 0) r.status = chm_pkg::ST_FULL;
            else begin
               m_free_n--;
               node = m_free[m_free_n];
               m_key[node] = key; m_val[node] = val;
               m_link[node] = 0; m_link_ok[node] = 0;
               if (has_prev) begin
                  m_link[prev] = 10'(node); m_link_ok[prev] = 1;
               end else begin
                  m_head[b] = 10'(node); m_head_ok[b] = 1;
               end
               m_total++;
            end
         end else begin
            if (!hit) r.status = chm_pkg::ST_MISSING;
            else begin
               if (has_prev) begin
                  m_link[prev] = m_link[node]; m_link_ok[prev] = m_link_ok[node];
               end else begin
                  m_head[b] = m_link[node]; m_head_ok[b] = m_link_ok[node];
               end
               m_link_ok[node] = 0;
               if (m_free_n < NPOOL) begin
                  m_free[m_free_n] = 10'(node); m_free_n++;
               end
               if (m_total > 0) m_total--;
            end
         end
      end
      r.entries = m_total[10:0];
      return r;
   endfunction

   task automatic send_request(logic [1:0] op, logic [31:0] key, logic [31:0] val);
      int gap;
      if (burst_mode && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, val, key, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp.push_back(predict_request(op, key, val));
   endtask

   task automatic drain();
      int guard;
      req_tvalid <= 0;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 200000) begin
         @(posedge clock); guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_bucket_count(logic [8:0] v);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      m_bucket_reg = v;
   endtask

   function automatic logic [31:0] pick_key();
      if (live_keys.size() != 0 && $urandom_range(0, 1))
         return live_keys[$urandom_range(0, live_keys.size() - 1)];
      case ($urandom_range(0, 2))
         0: return $urandom_range(0, 600);
         1: return $urandom;
         default: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      endcase
   endfunction

   task automatic issue(logic [1:0] op, logic [31:0] key, logic [31:0] val);
      send_request(op, key, val);
      if (op == chm_pkg::OP_INSERT) live_keys.push_back(key);
      if (live_keys.size() > 64) live_keys.delete(0);
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[44:0];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            exp = pending_rsp.pop_front();
            if (got !== exp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d val=%h n=%0d got st=%0d val=%h n=%0d",
                           exp.status, exp.found, exp.entries,
                           got.status, got.found, got.entries);
            end
         end
      end
   end

   // receiver stall pattern, with a long hold-off when requested
   always @(posedge clock) begin
      if (stall_seen != stall_asked) begin
         stall_seen <= stall_asked;
         stall_hold <= 400;
         rsp_tready <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_tready <= 0;
      end else if (!burst_mode) begin
         rsp_tready <= 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic test_directed();
      issue(chm_pkg::OP_LOOKUP, 32'd0, 32'd0);
      issue(chm_pkg::OP_REMOVE, 32'd0, 32'd0);
      issue(chm_pkg::OP_INSERT, 32'd0, 32'h0000_0000);
      issue(chm_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(chm_pkg::OP_INSERT, 32'd256, 32'hA5A5_5A5A);
      issue(chm_pkg::OP_INSERT, 32'd512, 32'h5A5A_A5A5);
      issue(chm_pkg::OP_INSERT, 32'd256, 32'h1234_5678);
      issue(chm_pkg::OP_LOOKUP, 32'd512, 32'd9);
      issue(chm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd0);
      issue(chm_pkg::OP_REMOVE, 32'd256, 32'd0);
      issue(chm_pkg::OP_LOOKUP, 32'd512, 32'd0);
      issue(chm_pkg::OP_REMOVE, 32'd256, 32'd0);
      issue(chm_pkg::OP_NONE, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
      issue(chm_pkg::OP_INSERT, 32'd256, 32'h0F0F_F0F0);
      issue(chm_pkg::OP_REMOVE, 32'd512, 32'd0);
      issue(chm_pkg::OP_LOOKUP, 32'd256, 32'd0);
      drain();
   endtask

   task automatic test_bucket_counts();
      write_bucket_count(9'd1);
      repeat (12) issue(2'($urandom_range(0, 2)), pick_key(), $urandom);
      drain();
      write_bucket_count(9'd0);
      repeat (10) issue(2'($urandom_range(0, 2)), pick_key(), $urandom);
      drain();
      write_bucket_count(9'h1FF);
      repeat (10) issue(2'($urandom_range(0, 2)), pick_key(), $urandom);
      drain();
      write_bucket_count(9'd7);
      repeat (10) issue(2'($urandom_range(0, 2)), pick_key(), $urandom);
      drain();
   endtask

   task automatic test_backpressure();
      stall_asked++;
      repeat (12) issue(chm_pkg::OP_LOOKUP, pick_key(), $urandom);
      drain();
   endtask

   task automatic test_random();
      int i, r;
      logic [1:0] op;
      for (i = 0; i < 480; i++) begin
         if (i % 120 == 0) begin
            drain();
            write_bucket_count(9'($urandom_range(1, 300)));
            burst_mode = (i != 240);
         end
         r = $urandom_range(0, 19);
         op = (r < 9) ? chm_pkg::OP_INSERT : (r < 14) ? chm_pkg::OP_LOOKUP :
              (r < 19) ? chm_pkg::OP_REMOVE : chm_pkg::OP_NONE;
         issue(op, pick_key(), $urandom);
      end
      burst_mode = 1;
      drain();
   endtask

   // sequential keys spread over many buckets, filled then emptied
   task automatic test_fill_drain();
      int i;
      write_bucket_count(9'd256);
      for (i = 0; i < 50; i++) send_request(chm_pkg::OP_INSERT, 32'h4000_0000 + i, i);
      drain();
      for (i = 0; i < 50; i++) send_request(chm_pkg::OP_REMOVE, 32'h4000_0000 + i, 0);
      drain();
   endtask

   initial begin
      m_bucket_reg = 9'd256;
      for (int i = 0; i < NBUCK; i++) begin
         m_head[i] = 0; m_head_ok[i] = 0;
      end
      for (int i = 0; i < NPOOL; i++) begin
         m_link_ok[i] = 0; m_free[i] = 10'(i);
         m_key[i] = 0; m_val[i] = 0; m_link[i] = 0;
      end
      m_free_n = NPOOL;
      m_total = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      test_directed();
      test_bucket_counts();
      test_backpressure();
      test_random();
      test_fill_drain();
      if (mismatches == 0 && pending_rsp.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #60ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
